// ===== design/gmcp_pkg.sv =====
// Package with shared constants, types and helpers of the grid path match unit.
`default_nettype none
package gmcp_pkg;
    localparam int MAX_GRID  = 32;
    localparam int COST_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_GRID);
    localparam int SIZE_W    = 6;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_GRID * MAX_GRID;
    localparam int ACC_W     = 22;
    localparam logic [ACC_W-1:0] TOTAL_MAX = {ACC_W{1'b1}};

    typedef enum logic [1:0] {
        PICK_LEFT = 2'd0,
        PICK_UP   = 2'd1,
        PICK_DIAG = 2'd2
    } pick_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FILL,
        ST_TRACE_RD,
        ST_TRACE_OUT
    } state_t;

    // One grid cell's cost token, offered to the cell chain during the fill sweep.
    typedef struct packed {
        logic                 valid;
        logic [IDX_W-1:0]     row;
        logic [IDX_W-1:0]     col;
        logic [COST_BITS-1:0] cost;
    } fill_tok_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ACC_W-1:0]  acc;
        pick_t             pick;
    } fill_res_t;

    function automatic logic [IDX_W-1:0] side_m1(input logic [SIZE_W-1:0] gs);
        logic [SIZE_W-1:0] n;
        if (gs < SIZE_W'(3)) n = SIZE_W'(3);
        else if (gs > SIZE_W'(MAX_GRID)) n = SIZE_W'(MAX_GRID);
        else n = gs;
        return IDX_W'(n - SIZE_W'(1));
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                  input logic [COST_BITS-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W+1)'(b);
        return s[ACC_W] ? TOTAL_MAX : s[ACC_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/gmcp_cell.sv =====
// One accumulation cell: holds the running row value of one column.
`default_nettype none
module gmcp_cell (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire gmcp_pkg::fill_tok_t          tok_in,
    input  wire logic [gmcp_pkg::ACC_W-1:0]   left_acc,
    input  wire logic [gmcp_pkg::ACC_W-1:0]   diag_acc,
    output gmcp_pkg::fill_res_t               res_out,
    output logic [gmcp_pkg::ACC_W-1:0]        prev_acc_out
);
    // acc_reg holds the value for the most recent row in this column.
    logic [gmcp_pkg::ACC_W-1:0] acc_reg, acc_next;
    gmcp_pkg::pick_t            pick;
    gmcp_pkg::fill_res_t        res_reg;
    logic [gmcp_pkg::ACC_W-1:0] up, best;

    always_comb begin
        up = acc_reg;
        if (tok_in.row == '0 && tok_in.col == '0) begin
            best = '0; pick = gmcp_pkg::PICK_DIAG;
        end else if (tok_in.row == '0) begin
            best = left_acc; pick = gmcp_pkg::PICK_LEFT;
        end else if (tok_in.col == '0) begin
            best = up; pick = gmcp_pkg::PICK_UP;
        end else if (left_acc < up && left_acc < diag_acc) begin
            best = left_acc; pick = gmcp_pkg::PICK_LEFT;
        end else if (up < diag_acc) begin
            best = up; pick = gmcp_pkg::PICK_UP;
        end else begin
            best = diag_acc; pick = gmcp_pkg::PICK_DIAG;
        end
        if (tok_in.row == '0 && tok_in.col == '0) acc_next = '0;
        else acc_next = gmcp_pkg::sat_add(best, tok_in.cost);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else begin
            res_reg.valid <= tok_in.valid;
        end
        res_reg.row  <= tok_in.row;
        res_reg.col  <= tok_in.col;
        res_reg.acc  <= acc_next;
        res_reg.pick <= pick;
        if (tok_in.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign res_out      = res_reg;
    assign prev_acc_out = acc_reg;
endmodule
`default_nettype wire

// ===== design/gmcp_chain.sv =====
// Row of cells, one per column; a cost token enters cell c at its own step.
`default_nettype none
module gmcp_chain (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire gmcp_pkg::fill_tok_t   tok_in,
    output gmcp_pkg::fill_res_t        res_out
);
    // The sweep feeds one grid cell at a time in row-major order; cell c handles column c.
    gmcp_pkg::fill_res_t         res   [gmcp_pkg::MAX_GRID];
    logic [gmcp_pkg::ACC_W-1:0]  prv   [gmcp_pkg::MAX_GRID];
    logic [gmcp_pkg::ACC_W-1:0]  left_reg, diag_reg;
    gmcp_pkg::fill_res_t         sel;

    for (genvar c = 0; c < gmcp_pkg::MAX_GRID; c++) begin : g_cell
        gmcp_pkg::fill_tok_t t;
        always_comb begin
            t = tok_in;
            t.valid = tok_in.valid && (tok_in.col == gmcp_pkg::IDX_W'(c));
        end
        gmcp_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .tok_in(t),
            .left_acc(left_reg), .diag_acc(diag_reg),
            .res_out(res[c]), .prev_acc_out(prv[c])
        );
    end

    // The diagonal is the cell's value of the row above, taken before the cell updates it.
    // The left value is the fresh result of that cell, taken in the cycle after.
    always_ff @(posedge aclk) begin
        if (tok_in.valid) begin
            diag_reg <= prv[tok_in.col];
        end
        if (sel.valid) begin
            left_reg <= sel.acc;
        end
    end

    always_comb begin
        sel = res[0];
        sel.valid = 1'b0;
        for (int c = 0; c < gmcp_pkg::MAX_GRID; c++) begin
            if (res[c].valid) sel = res[c];
        end
    end
    assign res_out = sel;
endmodule
`default_nettype wire

// ===== design/grid_min_cost_path_match_unit.sv =====
// Top level of the grid minimum-cost path match unit.
// Usage: write grid_size (N, clamped to 3..32) on the cfg channel; any write
// restarts loading. Then send N*N cost beats on s_axis in row-major order.
// After the beat that completes the grid the unit stops taking input, runs
// the accumulation sweep and traces the path from (N-1,N-1) back to (0,0),
// giving one m_axis beat per path cell (up to 2N-1), the origin last with
// m_axis_tlast high. Each result beat carries the running total and peak
// cost of the cells traced so far, the origin excluded.
// Loading takes one cost beat per cycle. The fill sweep issues a new grid
// cell to the cell chain only when no read is in flight, since each cell
// needs the fresh value of its left neighbor. Each traced cell passes a
// registered store read, then the output register. New cost beats are
// taken again once the last result beat has left the output register.
// When the receiver stalls, the result beat holds in the output register
// and the trace waits. Reset clears the load count, sets N to 32 and returns
// to loading; the stores are not cleared, as a run only reads what it wrote.
`default_nettype none
module grid_min_cost_path_match_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] cell_cost
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [4:0] path_row, [9:5] path_col,
                                             // [31:10] total_cost, [47:32] peak_cost
    output logic             m_axis_tlast,   // is_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data        // grid_size
);
    localparam int IW = gmcp_pkg::IDX_W;
    localparam int AW = gmcp_pkg::ADDR_W;
    localparam int CW = gmcp_pkg::COST_BITS;

    gmcp_pkg::state_t state_reg, state_next;
    logic [gmcp_pkg::SIZE_W-1:0] size_reg;
    logic [IW-1:0] lr_reg, lc_reg;          // load position
    logic [IW-1:0] fr_reg, fc_reg;          // fill read position
    logic          fdone_reg;
    logic [IW-1:0] tr_reg, tc_reg;          // trace position
    logic [gmcp_pkg::ACC_W-1:0] tot_reg;
    logic [CW-1:0] peak_reg;
    logic          ov_reg;
    logic [47:0]   od_reg;
    logic          ol_reg;
    logic [IW-1:0] nm1;

    // Stores: the cost memory and the choice memory.
    logic [CW-1:0] cost_mem [gmcp_pkg::DEPTH];
    logic [1:0]    pick_mem [gmcp_pkg::DEPTH];
    logic [CW-1:0] cost_rd_reg;
    logic [1:0]    pick_rd_reg;
    logic [AW-1:0] cost_ra;
    logic          fill_rd_reg;
    logic [IW-1:0] fr_d_reg, fc_d_reg;

    gmcp_pkg::fill_tok_t tok;
    gmcp_pkg::fill_res_t fres;
    logic s_acc, last_load, fill_end, trace_origin;
    logic fill_issue, trace_step;

    assign nm1 = gmcp_pkg::side_m1(size_reg);
    // Input waits until the last result beat of the previous grid has left.
    assign s_axis_tready = (state_reg == gmcp_pkg::ST_LOAD) && !ov_reg;
    assign cfg_ready     = 1'b1;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign last_load     = s_acc && lr_reg == nm1 && lc_reg == nm1;
    assign fill_end      = fres.valid && fres.row == nm1 && fres.col == nm1;
    assign trace_origin  = tr_reg == '0 && tc_reg == '0;
    assign cost_ra       = (state_reg == gmcp_pkg::ST_FILL) ? {fr_reg, fc_reg}
                                                            : {tr_reg, tc_reg};
    // The sweep reads a new cell only when no read is in flight, so each left value is ready.
    assign fill_issue    = state_reg == gmcp_pkg::ST_FILL && !fdone_reg && !fill_rd_reg;
    assign trace_step    = state_reg == gmcp_pkg::ST_TRACE_OUT && (!ov_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (s_acc) cost_mem[{lr_reg, lc_reg}] <= s_axis_tdata[CW-1:0];
        if (fres.valid) pick_mem[{fres.row, fres.col}] <= fres.pick;
        cost_rd_reg <= cost_mem[cost_ra];
        pick_rd_reg <= pick_mem[{tr_reg, tc_reg}];
    end

    always_comb begin
        tok.valid = fill_rd_reg;
        tok.row   = fr_d_reg;
        tok.col   = fc_d_reg;
        tok.cost  = cost_rd_reg;
    end

    gmcp_chain u_chain (.aclk(aclk), .aresetn(aresetn), .tok_in(tok), .res_out(fres));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gmcp_pkg::ST_LOAD:      if (last_load) state_next = gmcp_pkg::ST_FILL;
            gmcp_pkg::ST_FILL:      if (fill_end) state_next = gmcp_pkg::ST_TRACE_RD;
            gmcp_pkg::ST_TRACE_RD:  state_next = gmcp_pkg::ST_TRACE_OUT;
            gmcp_pkg::ST_TRACE_OUT: begin
                if (!ov_reg || m_axis_tready) begin
                    state_next = trace_origin ? gmcp_pkg::ST_LOAD : gmcp_pkg::ST_TRACE_RD;
                end
            end
            default:                state_next = gmcp_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gmcp_pkg::ST_LOAD;
            size_reg    <= gmcp_pkg::SIZE_W'(gmcp_pkg::MAX_GRID);
            lr_reg      <= '0;
            lc_reg      <= '0;
            fill_rd_reg <= 1'b0;
            ov_reg      <= 1'b0;
            fdone_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_rd_reg <= fill_issue;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
                lr_reg   <= '0;
                lc_reg   <= '0;
            end else if (s_acc) begin
                if (lc_reg == nm1) begin
                    lc_reg <= '0;
                    lr_reg <= (lr_reg == nm1) ? '0 : lr_reg + IW'(1);
                end else begin
                    lc_reg <= lc_reg + IW'(1);
                end
            end
            if (last_load) begin
                fr_reg <= '0; fc_reg <= '0; fdone_reg <= 1'b0;
            end
            if (fill_issue) begin
                fr_d_reg <= fr_reg;
                fc_d_reg <= fc_reg;
                if (fc_reg == nm1) begin
                    fc_reg <= '0;
                    if (fr_reg == nm1) fdone_reg <= 1'b1;
                    fr_reg <= fr_reg + IW'(1);
                end else begin
                    fc_reg <= fc_reg + IW'(1);
                end
            end
            if (fill_end) begin
                tr_reg <= nm1; tc_reg <= nm1;
                tot_reg <= '0; peak_reg <= '0;
            end
            if (trace_step) begin
                ov_reg <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                ov_reg <= 1'b0;
            end
            if (trace_step) begin
                logic [gmcp_pkg::ACC_W-1:0] t;
                logic [CW-1:0] p;
                t = trace_origin ? tot_reg : gmcp_pkg::sat_add(tot_reg, cost_rd_reg);
                p = (!trace_origin && cost_rd_reg > peak_reg) ? cost_rd_reg : peak_reg;
                tot_reg  <= t;
                peak_reg <= p;
                od_reg   <= {p, t, 5'(tc_reg), 5'(tr_reg)};
                ol_reg   <= trace_origin;
                priority if (tr_reg == '0) tc_reg <= tc_reg - IW'(1);
                else if (tc_reg == '0) tr_reg <= tr_reg - IW'(1);
                else if (pick_rd_reg == gmcp_pkg::PICK_LEFT) tc_reg <= tc_reg - IW'(1);
                else if (pick_rd_reg == gmcp_pkg::PICK_UP) tr_reg <= tr_reg - IW'(1);
                else begin
                    tr_reg <= tr_reg - IW'(1);
                    tc_reg <= tc_reg - IW'(1);
                end
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
endmodule
`default_nettype wire

// ===== design/gmcp_checker.sv =====
// Port-level checker for the grid path match unit, with its bind.
`default_nettype none
module gmcp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");
    a_noin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken during trace");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[9:0] == 10'd0)
        else $error("last beat is not the origin");
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[47:32] != 16'd0 |-> m_axis_tdata[31:10] != 22'd0)
        else $error("peak without total");
endmodule

bind grid_min_cost_path_match_unit gmcp_checker u_gmcp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

// ===== tb/grid_min_cost_path_match_unit_tb.sv =====
// Self-checking testbench of the grid minimum-cost path match unit.
`timescale 1ns / 100ps
`default_nettype none
module grid_min_cost_path_match_unit_tb;

    // Path cell as it appears on the result stream.
    typedef struct packed {
        logic [4:0]  row;
        logic [4:0]  col;
        logic [21:0] total;
        logic [15:0] peak;
        logic        last;
    } path_cell_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [15:0] cell_cost
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // [4:0] path_row, [9:5] path_col, [31:10] total, [47:32] peak
    logic        m_axis_tlast;    // is_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;        // grid_size

    grid_min_cost_path_match_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Predictor state: the grid as loaded, the side in use and the load position.
    logic [15:0]      grid_cost [gmcp_pkg::DEPTH];
    logic [21:0]      grid_acc  [gmcp_pkg::DEPTH];
    gmcp_pkg::pick_t  grid_pick [gmcp_pkg::DEPTH];
    int          side_now;
    int          cells_loaded;

    path_cell_t  path_queue[$];
    int          error_count;
    int          beats_checked;
    int          grids_done;
    bit          rx_stall_enable;

    function automatic int clamp_side(input logic [5:0] value);
        if (value < 3) return 3;
        if (value > gmcp_pkg::MAX_GRID) return gmcp_pkg::MAX_GRID;
        return value;
    endfunction

    // Accumulate the grid and push the traced path onto the expectation queue.
    task automatic predict_path();
        int r;
        int c;
        int here;
        logic [21:0] left;
        logic [21:0] up;
        logic [21:0] diag;
        logic [22:0] sum;
        logic [15:0] peak;
        logic [15:0] w;
        path_cell_t  entry;
        for (r = 0; r < side_now; r++) begin
            for (c = 0; c < side_now; c++) begin
                here = r * gmcp_pkg::MAX_GRID + c;
                w = grid_cost[here];
                if (r == 0 && c == 0) begin
                    grid_acc[here]  = '0;
                    grid_pick[here] = gmcp_pkg::PICK_DIAG;
                end else if (r == 0) begin
                    grid_acc[here]  = grid_acc[here - 1] + w;
                    grid_pick[here] = gmcp_pkg::PICK_LEFT;
                end else if (c == 0) begin
                    grid_acc[here]  = grid_acc[here - gmcp_pkg::MAX_GRID] + w;
                    grid_pick[here] = gmcp_pkg::PICK_UP;
                end else begin
                    left = grid_acc[here - 1];
                    up   = grid_acc[here - gmcp_pkg::MAX_GRID];
                    diag = grid_acc[here - gmcp_pkg::MAX_GRID - 1];
                    if (left < up && left < diag) begin
                        grid_acc[here]  = left + w;
                        grid_pick[here] = gmcp_pkg::PICK_LEFT;
                    end else if (up < diag) begin
                        grid_acc[here]  = up + w;
                        grid_pick[here] = gmcp_pkg::PICK_UP;
                    end else begin
                        grid_acc[here]  = diag + w;
                        grid_pick[here] = gmcp_pkg::PICK_DIAG;
                    end
                end
            end
        end
        // Trace back; the origin's cost never enters the sum or the peak.
        r = side_now - 1;
        c = side_now - 1;
        sum = '0;
        peak = '0;
        forever begin
            here = r * gmcp_pkg::MAX_GRID + c;
            if (r != 0 || c != 0) begin
                w = grid_cost[here];
                sum = sum + w;
                if (sum > 23'(gmcp_pkg::TOTAL_MAX)) sum = 23'(gmcp_pkg::TOTAL_MAX);
                if (w > peak) peak = w;
            end
            entry.row   = 5'(r);
            entry.col   = 5'(c);
            entry.total = sum[21:0];
            entry.peak  = peak;
            entry.last  = (r == 0 && c == 0);
            path_queue.push_back(entry);
            if (entry.last) break;
            if (r == 0) c--;
            else if (c == 0) r--;
            else if (grid_pick[here] == gmcp_pkg::PICK_LEFT) c--;
            else if (grid_pick[here] == gmcp_pkg::PICK_UP) r--;
            else begin
                r--;
                c--;
            end
        end
    endtask

    // Record one accepted cost beat; the beat that completes the grid predicts a path.
    task automatic load_cost(input logic [15:0] cost);
        grid_cost[(cells_loaded / side_now) * gmcp_pkg::MAX_GRID
                  + cells_loaded % side_now] = cost;
        cells_loaded++;
        if (cells_loaded == side_now * side_now) begin
            cells_loaded = 0;
            grids_done++;
            predict_path();
        end
    endtask

    // Result side: compare each accepted beat with the oldest expectation.
    int watchdog_count;
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            path_cell_t got;
            path_cell_t want;
            got.row   = m_axis_tdata[4:0];
            got.col   = m_axis_tdata[9:5];
            got.total = m_axis_tdata[31:10];
            got.peak  = m_axis_tdata[47:32];
            got.last  = m_axis_tlast;
            beats_checked++;
            if (path_queue.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
                error_count++;
            end else begin
                want = path_queue.pop_front();
                if (got.row !== want.row)
                    $display("%0t: path_row expected %0d actual %0d", $time, want.row, got.row);
                if (got.col !== want.col)
                    $display("%0t: path_col expected %0d actual %0d", $time, want.col, got.col);
                if (got.total !== want.total)
                    $display("%0t: total_cost expected %0d actual %0d",
                             $time, want.total, got.total);
                if (got.peak !== want.peak)
                    $display("%0t: peak_cost expected %0d actual %0d",
                             $time, want.peak, got.peak);
                if (got.last !== want.last)
                    $display("%0t: is_last expected %0b actual %0b", $time, want.last, got.last);
                if (got !== want) error_count++;
            end
        end
    end

    // Receiver: random stall bursts while enabled, otherwise always ready.
    initial begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_stall_enable && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog: cycles in a row without any accepted beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            watchdog_count <= 0;
        else
            watchdog_count <= watchdog_count + 1;
        if (watchdog_count >= WATCHDOG_LIMIT) begin
            $display("grid_min_cost_path_match_unit test failed");
            $finish;
        end
    end

    // Send one cost beat, with an optional random gap before it. Valid stays
    // high after the beat so that back-to-back beats need no second update.
    task automatic send_cost(input logic [15:0] cost, input bit gaps);
        if (gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cost;
        @(posedge aclk iff s_axis_tready);
        load_cost(cost);
    endtask

    // Wait for all results, then let the block settle before a register write.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (path_queue.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_size(input logic [5:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
        side_now = clamp_side(value);
        cells_loaded = 0;
    endtask

    // Directed rows: cost of each cell of a 3x3 grid, then the grid is traced.
    typedef struct {
        logic [15:0] cost [9];
        bit          known;   // last beat has an expectation typed in
        logic [21:0] total;
        logic [15:0] peak;
    } grid_row_t;

    grid_row_t directed_table [3];

    initial begin
        int g;
        int k;
        int n;
        int mode;
        logic [15:0] cost;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        aresetn       = 1'b0;
        error_count   = 0;
        beats_checked = 0;
        grids_done    = 0;
        rx_stall_enable = 1'b0;
        side_now      = gmcp_pkg::MAX_GRID;
        cells_loaded  = 0;

        // All zero: the path is the diagonal, totals stay zero.
        directed_table[0] = '{cost: '{default: 16'h0000}, known: 1, total: 0, peak: 0};
        // All at maximum: diagonal wins ties, so two non-origin cells are summed.
        directed_table[1] = '{cost: '{default: 16'hFFFF}, known: 1,
                              total: 22'd131070, peak: 16'hFFFF};
        // Mixed bit patterns and edge values: checked by the predictor only.
        directed_table[2] = '{cost: '{16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF,
                                      16'h0000, 16'hFFFE, 16'h1234, 16'hFFFF},
                              known: 0, total: 0, peak: 0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Below the minimum: taken as 3.
        write_size(6'd0);
        for (g = 0; g < 3; g++) begin
            for (k = 0; k < 9; k++) send_cost(directed_table[g].cost[k], 0);
            if (directed_table[g].known) begin
                if (path_queue[$].total !== directed_table[g].total ||
                    path_queue[$].peak !== directed_table[g].peak) begin
                    $display("%0t: directed grid %0d expected total %0d peak %0d, actual %0d %0d",
                             $time, g, directed_table[g].total, directed_table[g].peak,
                             path_queue[$].total, path_queue[$].peak);
                    error_count++;
                end
            end
        end

        // A write in the middle of a load discards the partial grid.
        write_size(6'd4);
        for (k = 0; k < 5; k++) send_cost(16'($urandom), 0);
        write_size(6'd3);

        // Random part: small grids with stalls on both sides.
        rx_stall_enable = 1'b1;
        for (g = 0; g < 4; g++) begin
            n = $urandom_range(3, 4);
            write_size(6'(n));
            mode = $urandom_range(0, 3);
            for (k = 0; k < n * n; k++) begin
                case (mode)
                    0: cost = 16'($urandom);
                    1: cost = 16'($urandom_range(0, 3));
                    2: cost = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: cost = 16'($urandom_range(0, 255));
                endcase
                send_cost(cost, 1);
            end
        end

        // Above the maximum: taken as 32; a partial load is then discarded.
        write_size(6'd63);
        for (k = 0; k < 8; k++) send_cost(16'($urandom), 0);

        // Final stretch with no idling on either side.
        rx_stall_enable = 1'b0;
        write_size(6'd3);
        for (k = 0; k < 18; k++) send_cost(16'($urandom), 0);
        s_axis_tvalid <= 1'b0;

        wait (path_queue.size() == 0);
        repeat (20) @(posedge aclk);
        $display("Ran %0d grids of side 3 and 4 with stalls, clamped sizes and partial loads.",
                 grids_done);
        $display("Checked %0d path beats against the predictor.", beats_checked);
        if (error_count == 0 && path_queue.size() == 0) begin
            $display("grid_min_cost_path_match_unit test passed");
        end else begin
            $display("grid_min_cost_path_match_unit test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
